// ===== hdl/lhs_pkg.sv =====
// Shared types and constants of the latency histogram statistics block.
package lhs_pkg;

  localparam int unsigned PLAYERS_DEF   = 256;
  localparam int unsigned BUCKETS_DEF   = 25;
  localparam int unsigned BUCKET_MS_DEF = 20;
  localparam int          CLIP_MS       = 10000;
  localparam int unsigned CHANNELS      = 2;
  localparam int unsigned SW            = 16;
  localparam int unsigned CW            = 32;
  localparam int unsigned BIW           = 6;

  typedef enum logic [2:0] {
    OP_CONNECT    = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_ADD        = 3'd2,
    OP_QUERY      = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]           operation;
    logic [7:0]           player;
    logic                 channel;
    logic signed [SW-1:0] sample_ms;
  } lhs_in_t;

  typedef struct packed {
    logic signed [SW-1:0] current_ms;
    logic signed [SW-1:0] average_ms;
    logic signed [SW-1:0] min_ms;
    logic signed [SW-1:0] max_ms;
    logic [BIW-1:0]       bucket_index;
    logic [CW-1:0]        bucket_count;
    logic [CW-1:0]        peak_count;
    logic                 last;
  } lhs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CLEAR_HI,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QRY_RD,
    ST_QRY_OUT,
    ST_PEAK,
    ST_DUMP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic clr_ch;
    logic sum_rd;
    logic add_wr;
    logic set_present;
    logic clr_present;
    logic bkt_rd;
    logic peak_acc;
    logic peak_clr;
    logic emit_query;
    logic emit_bucket;
    logic emit_last;
    logic [BIW-1:0] bkt;
  } lhs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic valid;
    logic present;
  } lhs_sts_t;

endpackage

// ===== hdl/lhs_ram.sv =====
// Generic RAM with one write port and one read port, registered read.
module lhs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/lhs_datapath.sv =====
// Statistics stores, sample arithmetic and result formatting.
module lhs_datapath #(
  parameter int unsigned PLAYERS   = lhs_pkg::PLAYERS_DEF,
  parameter int unsigned BUCKETS   = lhs_pkg::BUCKETS_DEF,
  parameter int unsigned BUCKET_MS = lhs_pkg::BUCKET_MS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lhs_pkg::lhs_in_t  item_i,
  input  lhs_pkg::lhs_cmd_t cmd_i,
  output lhs_pkg::lhs_sts_t sts_o,
  output logic              res_valid_o,
  output lhs_pkg::lhs_out_t res_o
);
  import lhs_pkg::*;

  localparam int unsigned PW    = (PLAYERS > 256) ? 8 : ((PLAYERS > 1) ? $clog2(PLAYERS) : 1);
  localparam int unsigned SLOTS = PLAYERS * CHANNELS;
  localparam int unsigned SLW   = $clog2(SLOTS);
  localparam int unsigned BDEP  = SLOTS * BUCKETS;
  localparam int unsigned BAW   = $clog2(BDEP);
  localparam int          TOP_MS = BUCKETS * BUCKET_MS;
  localparam int unsigned SUMW  = 4 * SW + 1;
  localparam int unsigned BSH   = 24;
  localparam longint unsigned BRCP = ((64'd1 << BSH) + 64'(BUCKET_MS) - 64'd1) / 64'(BUCKET_MS);
  localparam int unsigned ASH   = 23;
  localparam longint unsigned ARCP = ((64'd1 << ASH) + 64'd9) / 64'd10;

  lhs_in_t        item_q;
  logic [PLAYERS-1:0] present_q;
  logic [SLW-1:0] slot;
  logic [SLW-1:0] clr_slot;
  logic [BAW-1:0] baddr;
  logic [BIW-1:0] bsel;
  logic           valid;

  logic signed [SW-1:0] x_c;
  logic signed [SW-1:0] x_q;
  logic [BIW-1:0]       bidx_q;
  logic [BIW-1:0]       bidx;

  logic           s_we;
  logic [SUMW-1:0] s_wdata, s_rdata;
  logic           b_we;
  logic [CW-1:0]  b_wdata, b_rdata;

  logic signed [SW-1:0] cur_r, avg_r, min_r, max_r;
  logic                 has_r;
  logic signed [SW+4:0] avg_mul;
  logic [SW+4:0]        avg_mag;
  logic [63:0]          avg_prod;
  logic [SW+4:0]        avg_q10;
  logic signed [SW+4:0] avg_div;
  logic signed [SW-1:0] min_n, max_n;

  logic [CW-1:0] peak_q;
  logic          emit_q, emit_b_q, emit_l_q;
  logic [BIW-1:0] bkt_q;

  function automatic logic [BIW-1:0] bucket_of(logic signed [SW-1:0] x);
    logic [SW-2:0] mag;
    logic [63:0]   prod;
    mag  = x[SW-2:0];
    prod = 64'(mag) * 64'(BRCP);
    if (x < 0) return '0;
    if (32'(x) >= TOP_MS) return BIW'(BUCKETS - 1);
    return BIW'(prod >> BSH);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  assign valid    = ({24'd0, item_q.player} < 32'(PLAYERS));
  assign slot     = SLW'({item_q.player[PW-1:0], item_q.channel});
  assign clr_slot = SLW'({item_q.player[PW-1:0], cmd_i.clr_ch});
  assign sts_o.valid   = valid;
  assign sts_o.present = valid && present_q[item_q.player[PW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cmd_i.set_present && valid) begin
      present_q[item_q.player[PW-1:0]] <= 1'b1;
    end else if (cmd_i.clr_present && valid) begin
      present_q[item_q.player[PW-1:0]] <= 1'b0;
    end
  end

  // halve a channel 1 sample (toward zero) and clip it to CLIP_MS; bucket_of picks its bucket
  always_comb begin
    logic signed [SW-1:0] h;
    h = item_q.channel ? SW'((32'(item_q.sample_ms) + ((item_q.sample_ms < 0) ? 1 : 0)) >>> 1)
                       : item_q.sample_ms;
    x_c = (h > SW'(CLIP_MS)) ? SW'(CLIP_MS) : h;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_rd) begin
      x_q    <= x_c;
      bidx_q <= bucket_of(x_c);
    end
  end

  assign bidx  = cmd_i.add_wr ? bidx_q : cmd_i.bkt;
  assign bsel  = cmd_i.sum_rd ? BIW'(0) : bidx;
  assign baddr = BAW'(32'(slot) * BUCKETS + 32'(bsel));

  // summary store: {has, cur, avg, min, max}; clearing happens on connect
  assign {has_r, cur_r, avg_r, min_r, max_r} = s_rdata;

  assign avg_mul  = (SW+5)'(avg_r) * (SW+5)'(9) + (SW+5)'(x_q);
  assign avg_mag  = avg_mul[SW+4] ? (SW+5)'(-avg_mul) : (SW+5)'(avg_mul);
  assign avg_prod = 64'(avg_mag) * 64'(ARCP);
  assign avg_q10  = (SW+5)'(avg_prod >> ASH);
  assign avg_div  = avg_mul[SW+4] ? (SW+5)'(-$signed(avg_q10)) : $signed(avg_q10);
  assign min_n = (!has_r || x_q < min_r) ? x_q : min_r;
  assign max_n = (x_q > max_r) ? x_q : max_r;

  assign s_we    = cmd_i.clr_wr || cmd_i.add_wr;
  assign s_wdata = cmd_i.clr_wr ? '0 : {1'b1, x_q, SW'(avg_div), min_n, max_n};

  lhs_ram #(.WIDTH(SUMW), .DEPTH(SLOTS)) u_sum (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(cmd_i.clr_wr ? clr_slot : slot),
    .wdata_i(s_wdata),
    .raddr_i(slot),
    .rdata_o(s_rdata)
  );

  assign b_we    = cmd_i.clr_wr || cmd_i.add_wr;
  assign b_wdata = cmd_i.clr_wr ? '0 : ((b_rdata == '1) ? b_rdata : b_rdata + CW'(1));

  lhs_ram #(.WIDTH(CW), .DEPTH(BDEP)) u_bkt (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(cmd_i.clr_wr ? BAW'(32'(clr_slot) * BUCKETS + 32'(cmd_i.bkt)) : baddr),
    .wdata_i(b_wdata),
    .raddr_i(cmd_i.sum_rd ? BAW'(32'(slot) * BUCKETS + 32'(bucket_of(x_c))) : baddr),
    .rdata_o(b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q   <= 1'b0;
      emit_b_q <= 1'b0;
      emit_l_q <= 1'b0;
      bkt_q    <= '0;
      peak_q   <= '0;
    end else begin
      emit_q   <= cmd_i.emit_query;
      emit_b_q <= cmd_i.emit_bucket;
      emit_l_q <= cmd_i.emit_last;
      bkt_q    <= cmd_i.bkt;
      if (cmd_i.peak_clr) begin
        peak_q <= '0;
      end else if (cmd_i.peak_acc && b_rdata > peak_q) begin
        peak_q <= b_rdata;
      end
    end
  end

  always_comb begin
    res_o = '0;
    res_valid_o = emit_q || emit_b_q;
    if (emit_q) begin
      if (sts_o.present) begin
        res_o.current_ms = cur_r;
        res_o.average_ms = avg_r;
        res_o.min_ms     = min_r;
        res_o.max_ms     = max_r;
      end
      res_o.last = 1'b1;
    end else if (emit_b_q) begin
      res_o.bucket_index = bkt_q;
      res_o.bucket_count = b_rdata;
      res_o.peak_count   = peak_q;
      res_o.last         = emit_l_q;
    end
  end

endmodule

// ===== hdl/lhs_ctrl.sv =====
// Operation sequencer of the latency histogram statistics block.
module lhs_ctrl #(
  parameter int unsigned BUCKETS = lhs_pkg::BUCKETS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [2:0]        op_i,
  input  lhs_pkg::lhs_sts_t sts_i,
  output logic              busy,
  output lhs_pkg::lhs_cmd_t cmd_o
);
  import lhs_pkg::*;

  localparam int unsigned CNTW = BIW + 1;

  state_e state_q, state_d;
  logic [2:0] op_q;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (start && !busy) begin
        op_q <= op_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.bkt = cnt_q[BIW-1:0];
    busy    = (state_q != ST_IDLE);
    cmd_o.load = start && (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_i)
            OP_CONNECT, OP_DISCONNECT, OP_ADD, OP_QUERY, OP_DUMP: state_d = ST_CLEAR;
            default: state_d = ST_IDLE;
          endcase
          cnt_d = '0;
        end
      end
      ST_CLEAR: begin
        case (op_q)
          OP_CONNECT: begin
            if (sts_i.valid) begin
              cmd_o.clr_wr = 1'b1;
              if (cnt_q == CNTW'(BUCKETS - 1)) begin
                cnt_d = '0;
                state_d = ST_CLEAR_HI;
              end else begin
                cnt_d = cnt_q + CNTW'(1);
              end
            end else begin
              state_d = ST_IDLE;
            end
          end
          OP_DISCONNECT: begin
            cmd_o.clr_present = 1'b1;
            state_d = ST_IDLE;
          end
          OP_ADD: begin
            cmd_o.sum_rd = 1'b1;
            state_d = sts_i.present ? ST_ADD_WR : ST_IDLE;
          end
          OP_QUERY: state_d = ST_QRY_OUT;
          OP_DUMP: begin
            cmd_o.peak_clr = 1'b1;
            cmd_o.bkt = '0;
            cnt_d = CNTW'(1);
            state_d = sts_i.present ? ST_PEAK : ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CLEAR_HI: begin
        cmd_o.clr_wr = 1'b1;
        cmd_o.clr_ch = 1'b1;
        if (cnt_q == CNTW'(BUCKETS - 1)) begin
          cmd_o.set_present = 1'b1;
          state_d = ST_IDLE;
        end
        cnt_d = cnt_q + CNTW'(1);
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRY_OUT: begin
        cmd_o.emit_query = 1'b1;
        state_d = ST_IDLE;
      end
      ST_PEAK: begin
        cmd_o.peak_acc = 1'b1;
        if (cnt_q == CNTW'(BUCKETS)) begin
          cnt_d = '0;
          cmd_o.bkt = '0;
          state_d = ST_DUMP;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      ST_DUMP: begin
        cmd_o.emit_bucket = 1'b1;
        cmd_o.emit_last = (cnt_q == CNTW'(BUCKETS - 1));
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_add_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD_WR |-> $past(state_q) == ST_CLEAR) else $error("add write order");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> busy) else $error("busy during dump");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> cnt_q < CNTW'(BUCKETS)) else $error("dump counter range");
`endif

endmodule

// ===== hdl/latency_histogram_stats.sv =====
// Latency histogram statistics block: top level.
// One item is taken when start is high and busy is low; results appear on
// result_o for one cycle each with strobe high and cannot be stalled.
// Connect clears one bucket of one channel per cycle, both channels;
// disconnect clears the present flag; add sample does a summary and
// bucket read-modify-write (only a read for an absent player); query gives
// its one result in the cycle after busy falls; dump of a present player
// gives BUCKETS results one per cycle, the last in the cycle after busy
// falls; a dump of an absent player gives none, and unused codes leave
// busy low. Dump time is set by the single read port of the bucket
// memory: one pass finds the peak, a second gives the buckets.
module latency_histogram_stats #(
  parameter int unsigned PLAYERS   = lhs_pkg::PLAYERS_DEF,
  parameter int unsigned BUCKETS   = lhs_pkg::BUCKETS_DEF,
  parameter int unsigned BUCKET_MS = lhs_pkg::BUCKET_MS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lhs_pkg::lhs_in_t  item_i,
  output logic              strobe,
  output lhs_pkg::lhs_out_t result_o
);
  import lhs_pkg::*;

  lhs_cmd_t cmd;
  lhs_sts_t sts;

  lhs_ctrl #(.BUCKETS(BUCKETS)) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .op_i  (item_i.operation),
    .sts_i (sts),
    .busy  (busy),
    .cmd_o (cmd)
  );

  lhs_datapath #(
    .PLAYERS  (PLAYERS),
    .BUCKETS  (BUCKETS),
    .BUCKET_MS(BUCKET_MS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(strobe),
    .res_o      (result_o)
  );

endmodule
